// ----- hdl/csv_field_tokenizer_macros.svh -----
// Assertion macros for the CSV field tokenizer.
// Used by csv_field_tokenizer; synthesis builds define SYNTH to drop the checks.
`ifndef CSV_FIELD_TOKENIZER_MACROS_SVH
`define CSV_FIELD_TOKENIZER_MACROS_SVH

`ifndef SYNTH
// Property must hold at every rising clock edge outside reset
`define CSV_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("csv tokenizer check failed");
// Condition must never be true outside reset
`define CSV_NEVER(label, clk, rst_n, cond) \
  `CSV_ASSERT(label, clk, rst_n, !(cond))
`else
`define CSV_ASSERT(label, clk, rst_n, prop)
`define CSV_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ----- hdl/csv_tok_pkg.sv -----
// Types, codes and helpers shared by the CSV field tokenizer modules.
// No dependencies.
package csv_tok_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  // Parser states
  typedef enum logic [2:0] {
    ST_START       = 3'd0,
    ST_QUOTED      = 3'd1,
    ST_MAYBE_CLOSE = 3'd2,
    ST_AFTER_CLOSE = 3'd3,
    ST_FIRST_BYTE  = 3'd4,
    ST_UNQUOTED    = 3'd5
  } pstate_t;

  // Configuration register indexes
  localparam logic CFG_QUOTE = 1'b0;
  localparam logic CFG_DELIM = 1'b1;

  localparam logic [7:0] CHR_CR = 8'h0D;
  localparam logic [7:0] CHR_LF = 8'h0A;

  localparam logic [7:0] QUOTE_RST = 8'd34;
  localparam logic [7:0] DELIM_RST = 8'd44;

  // One result beat
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } tok_t;

  // Results caused by one input byte
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       r0;
    tok_t       r1;
  } tok_pair_t;

  function automatic tok_t mk_tok(input kind_t k, input logic [7:0] d);
    tok_t t;
    t.kind = k;
    t.data = (k == KIND_BYTE) ? d : 8'd0;
    t.last = 1'b0;
    return t;
  endfunction

endpackage

// ----- hdl/csv_tok_if.sv -----
// Handshake channels of the CSV field tokenizer: text bytes in, tokens out.
// Depends on csv_tok_pkg for the kind type.
interface csv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface csv_out_if import csv_tok_pkg::*;;
  logic       valid;
  logic       ready;
  kind_t      out_kind;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_kind, output out_byte, output last, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input last, output ready);
endinterface

// ----- hdl/csv_field_tokenizer.sv -----
// CSV field tokenizer: takes one byte of text per beat and issues content bytes,
// field ends and row ends. A byte is taken every cycle while the result queue has
// room for two tokens; each beat passes the input register and the result queue.
// One result beat leaves per cycle while the sink is ready, so a byte that releases
// a held first byte with the next token gives two beats, and the four-entry result
// queue soaks up such bursts. Configuration writes take effect on the next byte.
// Depends on csv_tok_pkg, csv_tok_if, csv_tok_parse and the macros header.
`include "csv_field_tokenizer_macros.svh"

module csv_field_tokenizer import csv_tok_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_idx,
  input  logic [7:0] cfg_data,
  csv_in_if.sink     in_ch,
  csv_out_if.source  out_ch
);

  localparam int QDEPTH = 4;
  localparam int PW     = $clog2(QDEPTH);

  logic [7:0] quote_r, delim_r;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eoi_r;

  tok_t       q_mem [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic [PW:0]   cnt_pop;
  logic          pop, room, s1_adv;
  logic [PW:0]   push_n;
  tok_pair_t     res;
  tok_t          head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_r <= QUOTE_RST;
      delim_r <= DELIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_QUOTE: quote_r <= cfg_data;
        CFG_DELIM: delim_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Queue room after this cycle's pop decides whether the input stage advances
  assign pop     = out_ch.valid && out_ch.ready;
  assign cnt_pop = cnt_r - {{PW{1'b0}}, pop};
  assign room    = cnt_pop <= (PW+1)'(QDEPTH - 2);
  assign s1_adv  = s1_valid_r && room;
  assign in_ch.ready = !s1_valid_r || room;

  // Input register: hold the beat until the parser takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.in_byte;
      s1_eoi_r  <= in_ch.end_of_input;
    end
  end

  csv_tok_parse u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (s1_adv),
    .in_byte         (s1_byte_r),
    .end_of_input    (s1_eoi_r),
    .quote_char      (quote_r),
    .field_delimiter (delim_r),
    .res             (res)
  );

  assign push_n = s1_adv ? {{(PW-1){1'b0}}, res.cnt} : '0;

  // Result queue storage
  always_ff @(posedge clk) begin
    if (s1_adv && res.cnt != 2'd0) begin
      q_mem[wp_r] <= res.r0;
    end
    if (s1_adv && res.cnt == 2'd2) begin
      q_mem[wp_r + PW'(1)] <= res.r1;
    end
  end

  // Result queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + push_n[PW-1:0];
      if (pop) rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_pop + push_n;
    end
  end

  assign head            = q_mem[rp_r];
  assign out_ch.valid    = cnt_r != '0;
  assign out_ch.out_kind = head.kind;
  assign out_ch.out_byte = head.data;
  assign out_ch.last     = head.last;

  `CSV_NEVER(a_cnt_bound, clk, rst_n, cnt_r > (PW+1)'(QDEPTH))
  `CSV_NEVER(a_kind_valid, clk, rst_n, out_ch.valid && out_ch.out_kind == KIND_RSVD)
  `CSV_ASSERT(a_mark_zero, clk, rst_n, (out_ch.valid && out_ch.out_kind != KIND_BYTE) |-> (out_ch.out_byte == 8'd0))
  `CSV_ASSERT(a_pair_last, clk, rst_n, (s1_adv && res.cnt == 2'd2) |-> (!res.r0.last && res.r1.last))
  `CSV_ASSERT(a_mark_last, clk, rst_n, (out_ch.valid && out_ch.out_kind != KIND_BYTE) |-> out_ch.last)

endmodule

// ----- hdl/csv_tok_parse.sv -----
// Parser state machine: turns one text byte into zero, one or two tokens.
// Depends on csv_tok_pkg.
module csv_tok_parse import csv_tok_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  input  logic [7:0] quote_char,
  input  logic [7:0] field_delimiter,
  output tok_pair_t  res
);

  pstate_t    st_r, st_nxt;
  logic [7:0] held_r, held_nxt;
  logic       cr_r, cr_nxt;
  logic       rhf_r, rhf_nxt;

  logic [7:0] x;
  logic       skip;
  logic       is_q, is_d, is_l;
  tok_pair_t  r;
  kind_t      end_kind;

  // State registers advance only on a processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_START;
      held_r <= 8'd0;
      cr_r   <= 1'b0;
      rhf_r  <= 1'b0;
    end else if (step) begin
      st_r   <= st_nxt;
      held_r <= held_nxt;
      cr_r   <= cr_nxt;
      rhf_r  <= rhf_nxt;
    end
  end

  // Fold line ends and classify the byte; an end-of-input beat clears the CR flag
  always_comb begin
    x      = in_byte;
    skip   = 1'b0;
    cr_nxt = 1'b0;
    if (!end_of_input && in_byte == CHR_CR) begin
      cr_nxt = 1'b1;
      x      = CHR_LF;
    end else if (cr_r && in_byte == CHR_LF) begin
      skip = 1'b1;
    end
    is_q     = (x == quote_char);
    is_d     = (x == field_delimiter);
    is_l     = (x == CHR_LF);
    end_kind = is_d ? KIND_FIELD : KIND_ROW;
  end

  // Next state and tokens
  always_comb begin
    st_nxt   = st_r;
    held_nxt = held_r;
    rhf_nxt  = rhf_r;
    r.cnt    = 2'd0;
    r.r0     = mk_tok(KIND_ROW, 8'd0);
    r.r1     = mk_tok(KIND_ROW, 8'd0);

    if (end_of_input) begin
      // Flush an open row, then go back to reset state
      if (st_r != ST_START || rhf_r) begin
        if (st_r == ST_FIRST_BYTE) begin
          r.r0  = mk_tok(KIND_BYTE, held_r);
          r.cnt = 2'd2;
        end else begin
          r.cnt = 2'd1;
        end
      end
      st_nxt   = ST_START;
      held_nxt = 8'd0;
      rhf_nxt  = 1'b0;
    end else if (!skip) begin
      unique case (st_r)
        ST_QUOTED: begin
          if (is_q) begin
            st_nxt = ST_MAYBE_CLOSE;
          end else begin
            r.r0  = mk_tok(KIND_BYTE, x);
            r.cnt = 2'd1;
          end
        end
        ST_MAYBE_CLOSE: begin
          if (is_q) begin
            r.r0   = mk_tok(KIND_BYTE, x);
            r.cnt  = 2'd1;
            st_nxt = ST_QUOTED;
          end else if (is_d || is_l) begin
            r.r0    = mk_tok(end_kind, 8'd0);
            r.cnt   = 2'd1;
            rhf_nxt = is_d;
            st_nxt  = ST_START;
          end else begin
            st_nxt = ST_AFTER_CLOSE;
          end
        end
        ST_AFTER_CLOSE: begin
          // Drop text after the closing quote
          if (is_d || is_l) begin
            r.r0    = mk_tok(end_kind, 8'd0);
            r.cnt   = 2'd1;
            rhf_nxt = is_d;
            st_nxt  = ST_START;
          end
        end
        ST_FIRST_BYTE: begin
          held_nxt = 8'd0;
          if (is_q) begin
            // Restart the field as quoted, drop the held byte
            st_nxt = ST_QUOTED;
          end else begin
            r.r0  = mk_tok(KIND_BYTE, held_r);
            r.cnt = 2'd2;
            if (is_d || is_l) begin
              r.r1    = mk_tok(end_kind, 8'd0);
              rhf_nxt = is_d;
              st_nxt  = ST_START;
            end else begin
              r.r1   = mk_tok(KIND_BYTE, x);
              st_nxt = ST_UNQUOTED;
            end
          end
        end
        ST_UNQUOTED: begin
          r.cnt = 2'd1;
          if (is_d || is_l) begin
            r.r0    = mk_tok(end_kind, 8'd0);
            rhf_nxt = is_d;
            st_nxt  = ST_START;
          end else begin
            r.r0 = mk_tok(KIND_BYTE, x);
          end
        end
        default: begin
          st_nxt = ST_START;
          if (is_q) begin
            st_nxt = ST_QUOTED;
          end else if (is_d) begin
            r.r0    = mk_tok(KIND_FIELD, 8'd0);
            r.cnt   = 2'd1;
            rhf_nxt = 1'b1;
          end else if (is_l) begin
            // Skip blank lines
            if (rhf_r) begin
              r.r0    = mk_tok(KIND_ROW, 8'd0);
              r.cnt   = 2'd1;
              rhf_nxt = 1'b0;
            end
          end else begin
            held_nxt = x;
            st_nxt   = ST_FIRST_BYTE;
          end
        end
      endcase
    end

    // Mark the final token of this byte
    if (r.cnt == 2'd1) r.r0.last = 1'b1;
    if (r.cnt == 2'd2) r.r1.last = 1'b1;
  end

  assign res = r;

endmodule

// ----- tb/tb_csv_field_tokenizer.sv -----
// Self-checking bench for csv_field_tokenizer: drives CSV text beats and checks tokens.
// Needs csv_tok_pkg, the csv_in_if / csv_out_if channels and the tokenizer RTL.
`timescale 1ns / 1ps

module tb_csv_field_tokenizer;
  import csv_tok_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_idx;
  logic [7:0] cfg_data;

  csv_in_if  in_bus ();
  csv_out_if out_bus ();

  csv_field_tokenizer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_bus),
    .out_ch   (out_bus)
  );

  always #5 clk = ~clk;

  // Tokenizer shadow: configuration and parse state
  logic [7:0] cur_quote = QUOTE_RST;
  logic [7:0] cur_delim = DELIM_RST;
  pstate_t    parse_st  = ST_START;
  logic [7:0] held_first = 8'd0;
  logic       after_cr   = 1'b0;
  logic       row_has_ended_field = 1'b0;

  tok_t new_toks[$];
  tok_t pending_tokens[$];

  int  mismatch_cnt = 0;
  int  beats_sent   = 0;
  bit  steady_flow  = 1'b0;

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic void add_tok(input kind_t k, input logic [7:0] d);
    tok_t t;
    t.kind = k;
    t.data = (k == KIND_BYTE) ? d : 8'd0;
    t.last = 1'b0;
    new_toks.push_back(t);
  endfunction

  // Close the open field: row end on a line end, field end on a delimiter
  function automatic void close_field(input logic is_line);
    if (is_line) begin
      row_has_ended_field = 1'b0;
      add_tok(KIND_ROW, 8'd0);
    end else begin
      row_has_ended_field = 1'b1;
      add_tok(KIND_FIELD, 8'd0);
    end
    parse_st = ST_START;
  endfunction

  // Work out the tokens one accepted beat produces and queue them
  function automatic void tokenize_beat(input logic [7:0] b, input logic eoi);
    logic [7:0] c;
    logic       skip;
    logic       is_q;
    logic       is_d;
    logic       is_l;
    c    = b;
    skip = 1'b0;
    new_toks.delete();
    if (eoi) begin
      if (parse_st != ST_START || row_has_ended_field) begin
        if (parse_st == ST_FIRST_BYTE) add_tok(KIND_BYTE, held_first);
        add_tok(KIND_ROW, 8'd0);
      end
      parse_st            = ST_START;
      held_first          = 8'd0;
      after_cr            = 1'b0;
      row_has_ended_field = 1'b0;
    end else begin
      // Fold CR, LF and CRLF into one LF
      if (c == CHR_CR) begin
        after_cr = 1'b1;
        c        = CHR_LF;
      end else if (after_cr && c == CHR_LF) begin
        after_cr = 1'b0;
        skip     = 1'b1;
      end else begin
        after_cr = 1'b0;
      end
      is_q = (c == cur_quote);
      is_d = (c == cur_delim);
      is_l = (c == CHR_LF);
      if (!skip) begin
        case (parse_st)
          ST_QUOTED: begin
            if (is_q) parse_st = ST_MAYBE_CLOSE;
            else add_tok(KIND_BYTE, c);
          end
          ST_MAYBE_CLOSE: begin
            if (is_q) begin
              add_tok(KIND_BYTE, c);
              parse_st = ST_QUOTED;
            end else if (is_d || is_l) begin
              close_field(!is_d);
            end else begin
              parse_st = ST_AFTER_CLOSE;
            end
          end
          ST_AFTER_CLOSE: begin
            if (is_d || is_l) close_field(!is_d);
          end
          ST_FIRST_BYTE: begin
            if (is_q) begin
              // Quote right after the first byte: drop it, field turns quoted
              held_first = 8'd0;
              parse_st   = ST_QUOTED;
            end else begin
              add_tok(KIND_BYTE, held_first);
              held_first = 8'd0;
              parse_st   = ST_UNQUOTED;
              if (is_d || is_l) close_field(!is_d);
              else add_tok(KIND_BYTE, c);
            end
          end
          ST_UNQUOTED: begin
            if (is_d || is_l) close_field(!is_d);
            else add_tok(KIND_BYTE, c);
          end
          default: begin
            parse_st = ST_START;
            if (is_q) begin
              parse_st = ST_QUOTED;
            end else if (is_d) begin
              close_field(1'b0);
            end else if (is_l) begin
              // Blank line gives nothing
              if (row_has_ended_field) close_field(1'b1);
            end else begin
              held_first = c;
              parse_st   = ST_FIRST_BYTE;
            end
          end
        endcase
      end
    end
    if (new_toks.size() != 0) new_toks[new_toks.size() - 1].last = 1'b1;
    foreach (new_toks[i]) pending_tokens.push_back(new_toks[i]);
  endfunction

  // Send one text beat after a random gap and predict its tokens on acceptance
  task automatic send_beat(input logic [7:0] b, input logic eoi);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.in_byte      <= b;
    in_bus.end_of_input <= eoi;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    tokenize_beat(b, eoi);
    beats_sent++;
  endtask

  // Drop valid, drain all expected tokens, then let the pipeline settle
  task automatic quiesce();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] v);
    quiesce();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    if (idx == CFG_QUOTE) cur_quote = v;
    else cur_delim = v;
  endtask

  // Byte with no special meaning under the current setting
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == cur_quote || b == cur_delim || b == CHR_CR || b == CHR_LF);
    return b;
  endfunction

  // One row of random fields, mostly well formed, with some noise mixed in
  task automatic send_record();
    int unsigned nfld;
    int unsigned mode;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  b;
    nfld = $urandom_range(1, 4);
    for (int f = 0; f < nfld; f++) begin
      mode = $urandom_range(0, 9);
      if (mode <= 4) begin
        len = $urandom_range(0, 4);
        repeat (len) send_beat(plain_byte(), 1'b0);
      end else if (mode <= 8) begin
        // Quoted field; one kind starts with a plain byte that the quote discards
        if (mode == 8) send_beat(plain_byte(), 1'b0);
        send_beat(cur_quote, 1'b0);
        len = $urandom_range(0, 5);
        repeat (len) begin
          pick = $urandom_range(0, 9);
          case (pick)
            0: begin
              send_beat(cur_quote, 1'b0);
              send_beat(cur_quote, 1'b0);
            end
            1: send_beat(cur_delim, 1'b0);
            2: send_beat(CHR_CR, 1'b0);
            3: send_beat(CHR_LF, 1'b0);
            default: begin
              do b = 8'($urandom_range(0, 255)); while (b == cur_quote);
              send_beat(b, 1'b0);
            end
          endcase
        end
        send_beat(cur_quote, 1'b0);
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 2)) send_beat(plain_byte(), 1'b0);
      end else begin
        repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0);
      end
      // Cut a row short now and then
      if ($urandom_range(0, 39) == 0) send_beat(8'($urandom_range(0, 255)), 1'b1);
      if (f == nfld - 1) begin
        repeat (($urandom_range(0, 7) == 0) ? 2 : 1) begin
          case ($urandom_range(0, 2))
            0: send_beat(CHR_LF, 1'b0);
            1: send_beat(CHR_CR, 1'b0);
            default: begin
              send_beat(CHR_CR, 1'b0);
              send_beat(CHR_LF, 1'b0);
            end
          endcase
        end
      end else begin
        send_beat(cur_delim, 1'b0);
      end
    end
    if ($urandom_range(0, 19) == 0) send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic run_setting(input logic [7:0] q, input logic [7:0] d, input int nrec);
    write_reg(CFG_QUOTE, q);
    write_reg(CFG_DELIM, d);
    repeat (nrec) send_record();
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Hand-picked text under the reset setting
  task automatic test_directed();
    send_beat(CHR_LF, 1'b0);       // blank line
    send_beat(8'h00, 1'b0);        // held first byte
    send_beat(8'hA5, 1'b1);        // flush held byte and row
    send_beat(8'h5A, 1'b1);        // nothing open
    send_beat("a", 1'b0);
    send_beat(cur_quote, 1'b0);    // restart as quoted, drop 'a'
    send_beat(CHR_CR, 1'b0);       // CR inside quotes becomes LF
    send_beat(CHR_LF, 1'b0);       // second half of CRLF
    send_beat(cur_quote, 1'b0);
    send_beat(cur_quote, 1'b0);    // doubled quote
    send_beat(cur_quote, 1'b0);    // closing quote
    send_beat("z", 1'b0);          // text after close is dropped
    send_beat(8'hFF, 1'b0);
    send_beat(cur_delim, 1'b0);
    send_beat(cur_delim, 1'b0);    // empty field
    send_beat(CHR_CR, 1'b0);       // line end after delimiter
    send_beat(CHR_LF, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat("b", 1'b0);          // releases held byte plus this one
    send_beat(CHR_LF, 1'b0);       // unquoted row end
    send_beat("c", 1'b0);
    send_beat(cur_delim, 1'b0);
    send_beat(8'h00, 1'b1);        // row with an ended field only
    send_beat(cur_quote, 1'b0);
    send_beat("q", 1'b0);
    send_beat(8'hFF, 1'b1);        // unterminated quote
  endtask

  // Extreme and overlapping register values
  task automatic test_config_settings();
    run_setting(8'h00, 8'hFF, 10);
    run_setting(8'hFF, 8'h00, 10);
    steady_flow = 1'b1;
    run_setting(8'h7C, 8'h7C, 10);   // quote and delimiter the same byte
    run_setting(CHR_LF, 8'h3B, 10);  // quote equals line end
    steady_flow = 1'b0;
    run_setting(8'h27, CHR_CR, 10);  // delimiter never seen after CR folding
    run_setting(8'h27, 8'h09, 10);
  endtask

  // Long random text, with occasional new settings, up to the overall beat count
  task automatic test_random_text();
    int goal;
    int next_setting;
    goal         = 1800;
    next_setting = beats_sent + 400;
    write_reg(CFG_QUOTE, QUOTE_RST);
    write_reg(CFG_DELIM, DELIM_RST);
    while (beats_sent < goal) begin
      if ($urandom_range(0, 24) == 0) steady_flow = !steady_flow;
      if (beats_sent >= next_setting) begin
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        if ($urandom_range(0, 1) == 0) begin
          write_reg(CFG_QUOTE, 8'($urandom_range(0, 255)));
          write_reg(CFG_DELIM, 8'($urandom_range(0, 255)));
        end else begin
          write_reg(CFG_QUOTE, QUOTE_RST);
          write_reg(CFG_DELIM, DELIM_RST);
        end
        next_setting = beats_sent + 400;
      end
      send_record();
    end
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Result side: random stall per beat, compare against oldest expectation
  initial begin : result_sink
    int unsigned stall;
    tok_t        want;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 13);
      @(negedge clk);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      if (pending_tokens.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat kind %0d byte %02h last %0b",
                                out_bus.out_kind, out_bus.out_byte, out_bus.last));
      end else begin
        want = pending_tokens.pop_front();
        if (out_bus.out_kind !== want.kind)
          flag_mismatch($sformatf("kind %0d, want %0d", out_bus.out_kind, want.kind));
        if (out_bus.out_byte !== want.data)
          flag_mismatch($sformatf("byte %02h, want %02h", out_bus.out_byte, want.data));
        if (out_bus.last !== want.last)
          flag_mismatch($sformatf("last %0b, want %0b", out_bus.last, want.last));
      end
    end
  end

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_QUOTE;
    cfg_data            = 8'd0;
    in_bus.valid        = 1'b0;
    in_bus.in_byte      = 8'd0;
    in_bus.end_of_input = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_config_settings();
    test_random_text();

    quiesce();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
